// ===== rtl/core/electrometer_current_calibration_unit_macros.svh =====
// assertion macros for the electrometer current calibration unit
// needs clk_i and rst_ni in the scope of the including module
`ifndef ELECTROMETER_CURRENT_CALIBRATION_UNIT_MACROS_SVH
`define ELECTROMETER_CURRENT_CALIBRATION_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ECC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// plain invariant, checked outside reset
`define ECC_ASSERT_ALWAYS(lbl, cond, msg) \
  `ECC_ASSERT_NOW(lbl, 1'b1, cond, msg)

`endif

// ===== rtl/core/ecc_pkg.sv =====
// shared types and constants of the current calibration unit
// no dependencies
package ecc_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned RES_W    = 48;
  localparam int unsigned FS_W     = 20;
  localparam int unsigned DMAG_W   = SAMPLE_W + 1;
  localparam int unsigned NUM_W    = DMAG_W + FS_W;
  localparam int unsigned QUO_W    = RES_W;
  localparam int unsigned LANES    = 4;
  // read, difference, magnitude, multiply, divider set-up, divider steps, output
  localparam int unsigned LANE_LAT = 6 + QUO_W;

  // configuration register indexes
  localparam logic [7:0] REG_RANGE_A = 8'd0;
  localparam logic [7:0] REG_RANGE_B = 8'd1;
  localparam logic [7:0] REG_RANGE_C = 8'd2;
  localparam logic [7:0] REG_RANGE_D = 8'd3;

  // input modes
  localparam logic MODE_CONVERT = 1'b0;
  localparam logic MODE_LOAD    = 1'b1;

  // full scale in 10 nA units per range selection
  function automatic logic [FS_W-1:0] full_scale(input logic [2:0] sel);
    logic [FS_W-1:0] fs;
    case (sel)
      3'd0:    fs = 20'd1000000;
      3'd1:    fs = 20'd100000;
      3'd2:    fs = 20'd10000;
      3'd3:    fs = 20'd1000;
      3'd4:    fs = 20'd100;
      3'd5:    fs = 20'd10;
      default: fs = 20'd1;
    endcase
    return fs;
  endfunction

  // one word in flight through the divider
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic              zero;
    logic              ovf;
    logic [31:0]       gmag;
    logic [31:0]       rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
  } div_t;

endpackage

// ===== rtl/core/ecc_div_step.sv =====
// one restoring division step, one quotient bit per stage
// depends on ecc_pkg
module ecc_div_step import ecc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  div_t st_i,
  output div_t st_o
);

  logic [32:0] trial;
  logic [32:0] sub;
  logic        ge;
  div_t        st_d;
  div_t        st_q;
  logic        valid_q;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {st_i.rem, st_i.low[QUO_W-1]};
    sub   = trial - {1'b0, st_i.gmag};
    ge    = trial >= {1'b0, st_i.gmag};
    st_d      = st_i;
    st_d.rem  = ge ? sub[31:0] : trial[31:0];
    st_d.low  = {st_i.low[QUO_W-2:0], 1'b0};
    st_d.quo  = {st_i.quo[QUO_W-2:0], ge};
  end

  // payload
  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= st_i.valid;
    end
  end

  always_comb begin
    st_o       = st_q;
    st_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/ecc_lane.sv =====
// one calibration lane: table memory, difference, scale, divider chain, clamp
// depends on ecc_pkg and ecc_div_step
module ecc_lane import ecc_pkg::*; #(
  parameter int unsigned RANGES        = 8,
  parameter int unsigned FRACTION_BITS = 16,
  localparam int unsigned IDX_W        = $clog2(RANGES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [2:0]              sel_i,
  input  logic [SAMPLE_W-1:0]     sample_i,
  input  logic                    wr_en_i,
  input  logic [IDX_W-1:0]        wr_addr_i,
  input  logic [SAMPLE_W-1:0]     wr_off_i,
  input  logic [SAMPLE_W-1:0]     wr_gain_i,
  output logic                    valid_o,
  output logic signed [RES_W-1:0] current_o,
  output logic                    zero_o,
  output logic                    sat_o
);

  localparam int unsigned NF_W = NUM_W + FRACTION_BITS;

  logic [SAMPLE_W-1:0] off_mem  [RANGES];
  logic [SAMPLE_W-1:0] gain_mem [RANGES];
  logic [IDX_W-1:0]    rd_addr;

  // stage 0: table read
  logic                v0_q;
  logic [SAMPLE_W-1:0] sample0_q, off0_q, gain0_q;
  logic [FS_W-1:0]     fs0_q;
  // stage 1: difference and gain magnitude
  logic                v1_q, gneg1_q, gzero1_q;
  logic [DMAG_W-1:0]   diff1_q;
  logic [31:0]         gmag1_q;
  logic [FS_W-1:0]     fs1_q;
  // stage 2: difference magnitude and sign
  logic                v2_q, neg2_q, zero2_q;
  logic [DMAG_W-1:0]   dmag2_q;
  logic [31:0]         gmag2_q;
  logic [FS_W-1:0]     fs2_q;
  // stage 3: scaled numerator
  logic                v3_q, neg3_q, zero3_q;
  logic [NUM_W-1:0]    num3_q;
  logic [31:0]         gmag3_q;
  // divider set-up
  logic [NF_W-1:0]       nfull;
  logic [NF_W-QUO_W-1:0] high;
  div_t                  div_d;
  div_t                  div_q;
  logic                  vdiv_q;
  div_t                  chain [QUO_W+1];
  // output clamp
  div_t                  fin;
  logic [RES_W-1:0]      lim, mag;
  logic                  sat;
  logic                  valid_q, zero_q, sat_q;
  logic [RES_W-1:0]      cur_q;

  assign rd_addr = (sel_i < RANGES) ? sel_i[IDX_W-1:0] : IDX_W'(RANGES - 1);

  // calibration memories
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      off_mem[wr_addr_i]  <= wr_off_i;
      gain_mem[wr_addr_i] <= wr_gain_i;
    end
  end

  always_ff @(posedge clk_i) begin
    off0_q    <= off_mem[rd_addr];
    gain0_q   <= gain_mem[rd_addr];
    sample0_q <= sample_i;
    fs0_q     <= full_scale(sel_i);
  end

  // stages 1 to 3 payload
  always_ff @(posedge clk_i) begin
    diff1_q  <= {sample0_q[SAMPLE_W-1], sample0_q} - {off0_q[SAMPLE_W-1], off0_q};
    gneg1_q  <= gain0_q[SAMPLE_W-1];
    gzero1_q <= (gain0_q == '0);
    gmag1_q  <= gain0_q[SAMPLE_W-1] ? (~gain0_q + 32'd1) : gain0_q;
    fs1_q    <= fs0_q;

    dmag2_q  <= diff1_q[DMAG_W-1] ? (~diff1_q + DMAG_W'(1)) : diff1_q;
    neg2_q   <= diff1_q[DMAG_W-1] ^ gneg1_q;
    zero2_q  <= gzero1_q;
    gmag2_q  <= gmag1_q;
    fs2_q    <= fs1_q;

    num3_q   <= NUM_W'(dmag2_q) * NUM_W'(fs2_q);
    neg3_q   <= neg2_q;
    zero3_q  <= zero2_q;
    gmag3_q  <= gmag2_q;
  end

  // divider set-up: top bits give the overflow test and the first remainder
  always_comb begin
    nfull      = {num3_q, {FRACTION_BITS{1'b0}}};
    high       = nfull[NF_W-1:QUO_W];
    div_d      = '0;
    div_d.valid = v3_q;
    div_d.neg  = neg3_q;
    div_d.zero = zero3_q;
    div_d.gmag = gmag3_q;
    div_d.ovf  = 64'(high) >= 64'(gmag3_q);
    div_d.rem  = 32'(high);
    div_d.low  = nfull[QUO_W-1:0];
    div_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  // valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vdiv_q <= 1'b0;
    end else begin
      v0_q   <= valid_i;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      vdiv_q <= v3_q;
    end
  end

  always_comb begin
    chain[0]       = div_q;
    chain[0].valid = vdiv_q;
  end

  // divider chain
  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    ecc_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .st_i   (chain[k]),
      .st_o   (chain[k+1])
    );
  end

  // clamp, sign and zero-gain override
  always_comb begin
    fin = chain[QUO_W];
    lim = fin.neg ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    sat = fin.ovf || (fin.quo > lim);
    mag = sat ? lim : fin.quo;
  end

  always_ff @(posedge clk_i) begin
    zero_q <= fin.zero;
    sat_q  <= !fin.zero && sat;
    if (fin.zero) begin
      cur_q <= '0;
    end else if (fin.neg) begin
      cur_q <= ~mag + RES_W'(1);
    end else begin
      cur_q <= mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= fin.valid;
    end
  end

  assign valid_o   = valid_q;
  assign current_o = cur_q;
  assign zero_o    = zero_q;
  assign sat_o     = sat_q;

endmodule

// ===== rtl/core/electrometer_current_calibration_unit.sv =====
// top level of the current calibration unit: config registers and four lanes
// depends on ecc_pkg, ecc_lane and the assertion macro header
//
//  port group        direction  handshake
//  command word      in         start && !busy
//  result word       out        done_o strobe, one cycle, no back-pressure
//  config word       in         cfg_valid_i && cfg_ready_o
//
// a word may be started every cycle; busy is never raised
// a result passes the front stages, divider set-up, the 48-step divider and output
// load words write a table entry and give no result
// reset clears the range selections and all valid bits; tables are unset until loaded
// config and command sides never stall
`include "electrometer_current_calibration_unit_macros.svh"
module electrometer_current_calibration_unit import ecc_pkg::*; #(
  parameter int unsigned CHANNELS      = 4,
  parameter int unsigned RANGES        = 8,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    mode_i,
  input  logic [SAMPLE_W-1:0]     sample_a_i,
  input  logic [SAMPLE_W-1:0]     sample_b_i,
  input  logic [SAMPLE_W-1:0]     sample_c_i,
  input  logic [SAMPLE_W-1:0]     sample_d_i,
  input  logic [1:0]              load_channel_i,
  input  logic [2:0]              load_range_i,
  input  logic [SAMPLE_W-1:0]     cal_offset_i,
  input  logic [SAMPLE_W-1:0]     cal_gain_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [7:0]              cfg_index_i,
  input  logic [7:0]              cfg_data_i,
  output logic                    done_o,
  output logic signed [RES_W-1:0] current_a_o,
  output logic signed [RES_W-1:0] current_b_o,
  output logic signed [RES_W-1:0] current_c_o,
  output logic signed [RES_W-1:0] current_d_o,
  output logic [LANES-1:0]        zero_gain_flags_o,
  output logic [LANES-1:0]        saturation_flags_o
);

  localparam int unsigned IDX_W = $clog2(RANGES);

  logic [2:0]          range_sel_q [LANES];
  logic                accept, conv, load_ok;
  logic [SAMPLE_W-1:0] samples [LANES];
  logic [LANES-1:0]    lane_valid;
  logic [RES_W-1:0]    lane_cur [LANES];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign conv        = accept && (mode_i == MODE_CONVERT);
  assign load_ok     = accept && (mode_i == MODE_LOAD) && (load_range_i < RANGES);

  assign samples[0] = sample_a_i;
  assign samples[1] = sample_b_i;
  assign samples[2] = sample_c_i;
  assign samples[3] = sample_d_i;

  // range selection registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) range_sel_q[i] <= 3'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RANGE_A: range_sel_q[0] <= cfg_data_i[2:0];
        REG_RANGE_B: range_sel_q[1] <= cfg_data_i[2:0];
        REG_RANGE_C: range_sel_q[2] <= cfg_data_i[2:0];
        REG_RANGE_D: range_sel_q[3] <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // lanes; channels past CHANNELS read as zero
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < CHANNELS) begin : g_on
      logic zero_l, sat_l;
      ecc_lane #(
        .RANGES        (RANGES),
        .FRACTION_BITS (FRACTION_BITS)
      ) u_lane (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .valid_i   (conv),
        .sel_i     (range_sel_q[i]),
        .sample_i  (samples[i]),
        .wr_en_i   (load_ok && (load_channel_i == 2'(i))),
        .wr_addr_i (load_range_i[IDX_W-1:0]),
        .wr_off_i  (cal_offset_i),
        .wr_gain_i (cal_gain_i),
        .valid_o   (lane_valid[i]),
        .current_o (lane_cur[i]),
        .zero_o    (zero_l),
        .sat_o     (sat_l)
      );
      assign zero_gain_flags_o[i]  = zero_l;
      assign saturation_flags_o[i] = sat_l;
    end else begin : g_off
      assign lane_valid[i]         = 1'b0;
      assign lane_cur[i]           = '0;
      assign zero_gain_flags_o[i]  = 1'b0;
      assign saturation_flags_o[i] = 1'b0;
    end
  end

  assign done_o      = lane_valid[0];
  assign current_a_o = lane_cur[0];
  assign current_b_o = lane_cur[1];
  assign current_c_o = lane_cur[2];
  assign current_d_o = lane_cur[3];

  // checks
  `ECC_ASSERT_NOW(a_flags_excl, done_o, (zero_gain_flags_o & saturation_flags_o) == '0, "zero gain and saturation together")
  `ECC_ASSERT_NOW(a_zero_cur, done_o && zero_gain_flags_o[0], current_a_o == '0, "zero gain gave a nonzero current")
  `ECC_ASSERT_NOW(a_latency, done_o, $past(conv, LANE_LAT), "result without a convert word")
  `ECC_ASSERT_ALWAYS(a_lanes_align, (lane_valid == '0) || (lane_valid[0] == 1'b1), "lanes out of step")

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the electrometer current calibration unit
// depends on ecc_pkg and electrometer_current_calibration_unit
// a scoreboard class predicts every result word; plain tasks drive the command and config ports
module tb_top;
  import ecc_pkg::*;

  localparam int unsigned SETTLE  = LANE_LAT + 8;
  localparam int unsigned WD_MAX  = 20000;
  localparam int unsigned N_CHAN  = 4;
  localparam int unsigned N_RANGE = 8;

  // one command word as driven
  typedef struct packed {
    logic                      mode;
    logic [3:0][SAMPLE_W-1:0]  sample;
    logic [1:0]                ch;
    logic [2:0]                rng;
    logic [SAMPLE_W-1:0]       off;
    logic [SAMPLE_W-1:0]       gain;
  } cmd_word_t;

  // one result word
  typedef struct packed {
    logic [3:0][RES_W-1:0] cur;
    logic [3:0]            zf;
    logic [3:0]            sf;
  } cur_word_t;

  // calibrated current predictor and store of pending current words
  class current_scoreboard;
    logic [SAMPLE_W-1:0] offset_tbl[N_CHAN*N_RANGE];
    logic [SAMPLE_W-1:0] gain_tbl[N_CHAN*N_RANGE];
    logic [2:0]          range_sel[4];
    cur_word_t           pending[$];
    int unsigned         mismatches;
    int unsigned         words_checked;
    int unsigned         loads_seen;
    int unsigned         sat_seen;
    int unsigned         zero_seen;

    function new();
      for (int i = 0; i < 4; i++) range_sel[i] = 3'd0;
      mismatches = 0;
      words_checked = 0;
      loads_seen = 0;
      sat_seen = 0;
      zero_seen = 0;
    endfunction

    function longint unsigned scale_of(input logic [2:0] sel);
      case (sel)
        3'd0:    return 64'd1000000;
        3'd1:    return 64'd100000;
        3'd2:    return 64'd10000;
        3'd3:    return 64'd1000;
        3'd4:    return 64'd100;
        3'd5:    return 64'd10;
        default: return 64'd1;
      endcase
    endfunction

    // config write, indexes above the lanes are dropped
    function void set_range(input logic [7:0] idx, input logic [7:0] data);
      if (idx < 8'd4) range_sel[idx] = data[2:0];
    endfunction

    // one lane: (sample - offset) * scale * 2^16 / gain, truncated and clamped
    function void lane(input logic [SAMPLE_W-1:0] s, input logic [SAMPLE_W-1:0] off,
                       input logic [SAMPLE_W-1:0] g, input logic [2:0] sel,
                       output logic [RES_W-1:0] cur, output logic zf, output logic sf);
      longint d, gs;
      longint unsigned dm, gm, num, q, r, mag, lim;
      bit neg;
      d  = longint'($signed(s)) - longint'($signed(off));
      gs = longint'($signed(g));
      zf = 1'b0;
      sf = 1'b0;
      cur = '0;
      if (gs == 0) begin
        zf = 1'b1;
        return;
      end
      neg = (d < 0) != (gs < 0);
      dm  = (d < 0) ? longint'(-d) : d;
      gm  = (gs < 0) ? longint'(-gs) : gs;
      num = dm * scale_of(sel);
      q   = num / gm;
      r   = num % gm;
      lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      if (q > (64'd1 << 31)) mag = lim + 1;
      else mag = (q << 16) + ((r << 16) / gm);
      if (mag > lim) begin
        sf  = 1'b1;
        mag = lim;
      end
      cur = neg ? RES_W'(-mag) : RES_W'(mag);
    endfunction

    // accepted command word: load a table entry or predict a current word
    function void note(input cmd_word_t w);
      cur_word_t e;
      int idx;
      if (w.mode == MODE_LOAD) begin
        offset_tbl[w.ch*N_RANGE + w.rng] = w.off;
        gain_tbl[w.ch*N_RANGE + w.rng]   = w.gain;
        loads_seen++;
        return;
      end
      for (int i = 0; i < 4; i++) begin
        idx = i*N_RANGE + range_sel[i];
        lane(w.sample[i], offset_tbl[idx], gain_tbl[idx], range_sel[i],
             e.cur[i], e.zf[i], e.sf[i]);
      end
      if (e.sf != 0) sat_seen++;
      if (e.zf != 0) zero_seen++;
      pending.push_back(e);
    endfunction

    function void fail_note(input cur_word_t exp_w, input cur_word_t act_w, input bit none);
      mismatches++;
      if (mismatches <= 10) begin
        if (none) $display("unexpected result word: %h", act_w);
        else begin
          $display("mismatch on result word %0d", words_checked);
          for (int i = 0; i < 4; i++)
            $display("  lane %0d current exp %h act %h", i, exp_w.cur[i], act_w.cur[i]);
          $display("  zero flags exp %b act %b, sat flags exp %b act %b",
                   exp_w.zf, act_w.zf, exp_w.sf, act_w.sf);
        end
      end
    endfunction

    // result word against the oldest prediction, field by field
    function void check(input cur_word_t a);
      cur_word_t e;
      bit bad;
      if (pending.size() == 0) begin
        fail_note(a, a, 1'b1);
        return;
      end
      e = pending.pop_front();
      bad = (e.zf !== a.zf) || (e.sf !== a.sf);
      for (int i = 0; i < 4; i++) if (e.cur[i] !== a.cur[i]) bad = 1'b1;
      if (bad) fail_note(e, a, 1'b0);
      words_checked++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                mode_i = MODE_CONVERT;
  logic [SAMPLE_W-1:0] sample_a_i = '0, sample_b_i = '0, sample_c_i = '0, sample_d_i = '0;
  logic [1:0]          load_channel_i = '0;
  logic [2:0]          load_range_i = '0;
  logic [SAMPLE_W-1:0] cal_offset_i = '0, cal_gain_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [7:0]          cfg_index_i = '0, cfg_data_i = '0;
  logic                done_o;
  logic signed [RES_W-1:0] current_a_o, current_b_o, current_c_o, current_d_o;
  logic [LANES-1:0]    zero_gain_flags_o, saturation_flags_o;

  current_scoreboard sb = new();
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;
  int unsigned cmd_words = 0;
  int unsigned cfg_words = 0;

  electrometer_current_calibration_unit i_dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i,
    .sample_a_i, .sample_b_i, .sample_c_i, .sample_d_i,
    .load_channel_i, .load_range_i, .cal_offset_i, .cal_gain_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .current_a_o, .current_b_o, .current_c_o, .current_d_o,
    .zero_gain_flags_o, .saturation_flags_o
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // monitor: accepted command words, result words and the watchdog
  always @(posedge clk_i) begin
    cmd_word_t w;
    cur_word_t r;
    bit        active;
    if (rst_ni) begin
      active = 1'b0;
      if (start && !busy) begin
        w.mode = mode_i;
        w.sample = {sample_d_i, sample_c_i, sample_b_i, sample_a_i};
        w.ch = load_channel_i;
        w.rng = load_range_i;
        w.off = cal_offset_i;
        w.gain = cal_gain_i;
        sb.note(w);
        cmd_words++;
        active = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) active = 1'b1;
      if (done_o) begin
        r.cur = {current_d_o, current_c_o, current_b_o, current_a_o};
        r.zf = zero_gain_flags_o;
        r.sf = saturation_flags_o;
        sb.check(r);
        active = 1'b1;
      end
      // one update of the idle count per cycle
      if (active) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_MAX) begin
        $display("watchdog expired, %0d words pending", sb.pending.size());
        $display("electrometer_current_calibration_unit test failed");
        $finish;
      end
    end
  end

  // send one command word, with random idle cycles ahead of it
  task automatic send_word(input cmd_word_t w);
    bit ok;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= w.mode;
    sample_a_i <= w.sample[0];
    sample_b_i <= w.sample[1];
    sample_c_i <= w.sample[2];
    sample_d_i <= w.sample[3];
    load_channel_i <= w.ch;
    load_range_i <= w.rng;
    cal_offset_i <= w.off;
    cal_gain_i <= w.gain;
    do begin
      @(negedge clk_i);
      ok = !busy;
      @(posedge clk_i);
    end while (!ok);
  endtask

  // wait for all pending words, then let the pipeline drain
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // one config write, only while idle
  task automatic write_cfg(input logic [7:0] idx, input logic [7:0] data);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    sb.set_range(idx, data);
    cfg_valid_i <= 1'b0;
    cfg_words++;
    @(posedge clk_i);
  endtask

  task automatic set_ranges(input logic [2:0] a, input logic [2:0] b,
                            input logic [2:0] c, input logic [2:0] d);
    // upper data bits are ignored by the block
    write_cfg(REG_RANGE_A, {5'($urandom), a});
    write_cfg(REG_RANGE_B, {5'($urandom), b});
    write_cfg(REG_RANGE_C, {5'($urandom), c});
    write_cfg(REG_RANGE_D, {5'($urandom), d});
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_gain();
    int unsigned k;
    logic [SAMPLE_W-1:0] g;
    k = $urandom_range(15);
    if (k == 0) g = '0;
    else if (k < 5) g = $urandom;
    else if (k < 10) g = $urandom_range(1, 1000);
    else g = $urandom_range(1000, 2000000);
    if (k >= 5 && $urandom_range(1)) g = -g;
    return g;
  endfunction

  function automatic cmd_word_t load_word(input logic [1:0] ch, input logic [2:0] rng,
                                          input logic [31:0] off, input logic [31:0] g);
    cmd_word_t w;
    w.mode = MODE_LOAD;
    for (int i = 0; i < 4; i++) w.sample[i] = $urandom;
    w.ch = ch;
    w.rng = rng;
    w.off = off;
    w.gain = g;
    return w;
  endfunction

  function automatic cmd_word_t conv_word(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    cmd_word_t w;
    w.mode = MODE_CONVERT;
    w.sample = {d, c, b, a};
    w.ch = 2'($urandom);
    w.rng = 3'($urandom);
    w.off = $urandom;
    w.gain = $urandom;
    return w;
  endfunction

  // random convert word: mostly near the table offset, some full range
  function automatic cmd_word_t rand_conv();
    logic [3:0][31:0] s;
    int idx;
    for (int i = 0; i < 4; i++) begin
      idx = i*N_RANGE + sb.range_sel[i];
      if ($urandom_range(3) == 0) s[i] = $urandom;
      else s[i] = sb.offset_tbl[idx] + 32'($signed($urandom_range(0, 4000)) - 2000);
    end
    return conv_word(s[0], s[1], s[2], s[3]);
  endfunction

  initial begin
    cmd_word_t w;
    logic [31:0] ext[4];
    ext[0] = 32'h7FFF_FFFF;
    ext[1] = 32'h8000_0000;
    ext[2] = 32'h0000_0000;
    ext[3] = 32'hFFFF_FFFF;

    // reset
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every table entry so no unset entry is ever read
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 8; r++)
        send_word(load_word(2'(c), 3'(r), 32'($urandom_range(0, 4000)) - 32'd2000,
                            32'($urandom_range(100, 100000))));

    // directed: zero gain, unit gains, extreme offsets
    send_word(load_word(2'd0, 3'd0, 32'd0, 32'd0));
    send_word(load_word(2'd1, 3'd0, 32'h8000_0000, 32'd1));
    send_word(load_word(2'd2, 3'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_word(load_word(2'd3, 3'd0, 32'd0, 32'h8000_0000));
    send_word(load_word(2'd3, 3'd7, 32'd5, 32'h7FFF_FFFF));
    send_word(load_word(2'd2, 3'd6, 32'd0, 32'd3));
    drain();
    set_ranges(3'd0, 3'd0, 3'd0, 3'd0);
    for (int i = 0; i < 4; i++)
      send_word(conv_word(ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4]));
    send_word(conv_word(32'd1, 32'h8000_0001, 32'h7FFF_FFFE, 32'd12345));
    drain();
    // selections 6 and 7 share the smallest scale, 7 uses its own entry
    set_ranges(3'd5, 3'd3, 3'd6, 3'd7);
    for (int i = 0; i < 4; i++)
      send_word(conv_word(ext[i], ext[(i+2)%4], 32'd7, ext[(i+3)%4]));
    drain();
    write_cfg(8'd4, 8'hFF);
    write_cfg(8'hFF, 8'h00);

    // random: three idle settings, each split into config batches
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 31 : (ph == 1) ? 59 : 0;
      for (int b = 0; b < 6; b++) begin
        drain();
        case (b)
          0:       set_ranges(3'd0, 3'd0, 3'd0, 3'd0);
          1:       set_ranges(3'd7, 3'd7, 3'd7, 3'd7);
          default: set_ranges(3'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
        endcase
        if ($urandom_range(2) == 0) write_cfg(8'($urandom_range(4, 255)), 8'($urandom));
        for (int n = 0; n < 36; n++) begin
          if ($urandom_range(4) == 0)
            w = load_word(2'($urandom), 3'($urandom), $urandom, rand_gain());
          else w = rand_conv();
          send_word(w);
        end
      end
    end

    drain();
    $display("covered %0d command words (%0d loads), %0d config writes", cmd_words,
             sb.loads_seen, cfg_words);
    $display("checked %0d result words, %0d with saturation, %0d with zero gain",
             sb.words_checked, sb.sat_seen, sb.zero_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("electrometer_current_calibration_unit test passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("electrometer_current_calibration_unit test failed");
    end
    $finish;
  end

endmodule
